// ===== sv/rolling_illiquidity_ratio_macros.svh =====
// Assertion macros for the rolling illiquidity ratio block.
`ifndef ROLLING_ILLIQUIDITY_RATIO_MACROS_SVH
`define ROLLING_ILLIQUIDITY_RATIO_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RILL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rolling_illiquidity_ratio: check failed");

// next-cycle implication
`define RILL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rolling_illiquidity_ratio: check failed");

`endif

// ===== sv/rill_pkg.sv =====
// Shared types and constants of the rolling illiquidity ratio block.
package rill_pkg;

    localparam int PRICE_W   = 32;
    localparam int AMT_W     = 48;
    localparam int SCALE_W   = 32;
    localparam int WLEN_W    = 8;
    localparam int RATIO_W   = 56;
    localparam int PROD_W    = PRICE_W + SCALE_W;
    localparam int DEN_W     = PRICE_W + AMT_W;
    localparam int FRAC_W    = 32;
    localparam int DIV_CNT_W = $clog2(RATIO_W);
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(20);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000000000);

    typedef enum logic {
        REG_WINDOW = 1'b0,
        REG_SCALE  = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DEN,
        S_RSTART,
        S_RWAIT,
        S_UPD,
        S_MSTART,
        S_MWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [WLEN_W-1:0]  window_length;
        logic [SCALE_W-1:0] scale_factor;
        logic               clear;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [DEN_W-1:0]   hi;
        logic [RATIO_W-1:0] lo;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [RATIO_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== sv/rill_ifs.sv =====
// Valid/ready channel interfaces for bars in and results out.
interface rill_bar_if;
    logic                         valid;
    logic                         ready;
    logic                         first_bar;
    logic [rill_pkg::PRICE_W-1:0] close_price;
    logic [rill_pkg::AMT_W-1:0]   traded_amount;

    modport source(output valid, first_bar, close_price, traded_amount, input ready);
    modport sink(input valid, first_bar, close_price, traded_amount, output ready);
endinterface

interface rill_res_if;
    logic                         valid;
    logic                         ready;
    logic [rill_pkg::RATIO_W-1:0] bar_ratio;
    logic                         bar_ratio_valid;
    logic [rill_pkg::RATIO_W-1:0] window_mean;
    logic                         mean_valid;

    modport source(output valid, bar_ratio, bar_ratio_valid, window_mean, mean_valid,
                   input ready);
    modport sink(input valid, bar_ratio, bar_ratio_valid, window_mean, mean_valid,
                 output ready);
endinterface

// ===== sv/rill_ring.sv =====
// Ratio ring memory: one write port, one registered read port.
module rill_ring #(
    parameter int DEPTH = 128
) (
    input  logic                         i_clk,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [rill_pkg::RATIO_W:0]   o_rdata,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [rill_pkg::RATIO_W:0]   i_wdata
);
    logic [rill_pkg::RATIO_W:0] r_mem [DEPTH];
    logic [rill_pkg::RATIO_W:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/rill_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 56-bit saturated result.
module rill_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rill_pkg::t_div_req i_req,
    output rill_pkg::t_div_rsp o_rsp
);
    logic                              r_busy;
    logic                              r_done;
    logic [rill_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [rill_pkg::DEN_W-1:0]        r_rem;
    logic [rill_pkg::DEN_W-1:0]        r_den;
    logic [rill_pkg::RATIO_W-1:0]      r_q;
    logic                              r_sat;
    logic [rill_pkg::DEN_W:0]          trial;
    logic [rill_pkg::DEN_W:0]          diff;
    logic                              ge;

    assign trial = {r_rem, r_q[rill_pkg::RATIO_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= rill_pkg::DIV_CNT_W'(rill_pkg::RATIO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - rill_pkg::DIV_CNT_W'(1);
            end
        end
    end

    // remainder starts at the high part; quotient bits shift in behind the low part
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.hi;
            r_q   <= i_req.lo;
            r_den <= i_req.den;
            r_sat <= i_req.hi >= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[rill_pkg::DEN_W-1:0] : trial[rill_pkg::DEN_W-1:0];
            r_q   <= {r_q[rill_pkg::RATIO_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? '1 : r_q;
endmodule

// ===== sv/rill_cfg.sv =====
// APB configuration registers: window length and scale factor.
module rill_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rill_pkg::APB_AW-1:0]  paddr,
    input  logic [rill_pkg::APB_DW-1:0]  pwdata,
    output logic [rill_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output rill_pkg::t_cfg               o_cfg
);
    logic [rill_pkg::WLEN_W-1:0]  r_window;
    logic [rill_pkg::SCALE_W-1:0] r_scale;
    rill_pkg::t_reg_idx           idx;
    logic                         wr;

    assign idx    = rill_pkg::t_reg_idx'(paddr[2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= rill_pkg::WLEN_RESET;
            r_scale  <= rill_pkg::SCALE_RESET;
        end else if (wr) begin
            unique case (idx)
                rill_pkg::REG_WINDOW: r_window <= pwdata[rill_pkg::WLEN_W-1:0];
                rill_pkg::REG_SCALE:  r_scale  <= pwdata[rill_pkg::SCALE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rill_pkg::REG_WINDOW: prdata = rill_pkg::APB_DW'(r_window);
            rill_pkg::REG_SCALE:  prdata = rill_pkg::APB_DW'(r_scale);
        endcase
    end

    assign o_cfg.window_length = r_window;
    assign o_cfg.scale_factor  = r_scale;
    assign o_cfg.clear         = wr && (idx == rill_pkg::REG_WINDOW);
endmodule

// ===== sv/rolling_illiquidity_ratio.sv =====
// Top level: rolling mean of per-bar |return|/amount ratios over a ring memory.
//
//  port    dir  handshake     carries
//  i_bar   in   valid/ready   first_bar, close_price, traded_amount
//  o_res   out  valid/ready   bar_ratio, bar_ratio_valid, window_mean, mean_valid
//  apb     in   psel/penable  window_length at 0x0, scale_factor at 0x4
//
// A transaction with both divisions makes two passes through the shared divider, one for
// the ratio and one for the mean; a bar with no ratio or no mean skips that pass.
// Reset is synchronous; the ring needs no clearing pass after reset.
// One result waits in the output register while the next bar is taken in.
// A stalled output holds the FSM in S_OUT only once a second result is ready.
`include "rolling_illiquidity_ratio_macros.svh"

module rolling_illiquidity_ratio #(
    parameter int MAX_WINDOW = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rill_bar_if.sink                     i_bar,
    rill_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rill_pkg::APB_AW-1:0]  paddr,
    input  logic [rill_pkg::APB_DW-1:0]  pwdata,
    output logic [rill_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (WW > rill_pkg::WLEN_W) ? WW : rill_pkg::WLEN_W;
    localparam int SW    = rill_pkg::RATIO_W + AW;
    localparam int RW    = rill_pkg::RATIO_W;

    rill_pkg::t_cfg     cfg;
    rill_pkg::t_div_req div_req;
    rill_pkg::t_div_rsp div_rsp;
    rill_pkg::t_state   r_state, n_state;

    logic [WW-1:0]   eff_win;
    logic            accept;
    logic            out_load;
    logic            ring_re, ring_we;
    logic [RW:0]     ring_rdata;

    logic                           r_first;
    logic [rill_pkg::PRICE_W-1:0]   r_close;
    logic [rill_pkg::AMT_W-1:0]     r_amount;
    logic [rill_pkg::PROD_W-1:0]    r_prod;
    logic [rill_pkg::DEN_W-1:0]     r_den;
    logic                           r_has_ratio;
    logic                           r_valid;
    logic [RW-1:0]                  r_ratio;
    logic [RW-1:0]                  r_mean;
    logic                           r_mvalid;

    logic [SW-1:0]                  r_sum;
    logic [WW-1:0]                  r_count;
    logic [WW-1:0]                  r_seen;
    logic [AW-1:0]                  r_slot;
    logic [rill_pkg::PRICE_W-1:0]   r_prev;

    logic                           r_out_valid;
    logic [RW-1:0]                  r_o_ratio;
    logic                           r_o_rvalid;
    logic [RW-1:0]                  r_o_mean;
    logic                           r_o_mvalid;

    logic [rill_pkg::PRICE_W-1:0]   prev_eff;
    logic [AW-1:0]                  slot_base, slot_eff;
    logic [rill_pkg::PRICE_W-1:0]   diff;
    logic                           evict;
    logic                           mvalid_now;
    logic [WW-1:0]                  slot_inc;

    rill_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rill_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rill_ring #(.DEPTH(MAX_WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_re    (ring_re),
        .i_raddr (slot_eff),
        .o_rdata (ring_rdata),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata ({r_valid, r_ratio})
    );

    always_comb begin
        if (cfg.window_length == '0) begin
            eff_win = WW'(1);
        end else if (CMP_W'(cfg.window_length) > CMP_W'(MAX_WINDOW)) begin
            eff_win = WW'(MAX_WINDOW);
        end else begin
            eff_win = WW'(cfg.window_length);
        end
    end

    assign accept     = i_bar.valid && i_bar.ready;
    assign i_bar.ready = (r_state == rill_pkg::S_IDLE);
    assign out_load   = (r_state == rill_pkg::S_OUT) && (!r_out_valid || o_res.ready);

    assign prev_eff   = r_first ? '0 : r_prev;
    assign slot_base  = r_first ? '0 : r_slot;
    assign slot_eff   = (WW'(slot_base) >= eff_win) ? '0 : slot_base;
    assign diff       = (r_close > prev_eff) ? r_close - prev_eff : prev_eff - r_close;
    assign evict      = (r_seen >= eff_win) && ring_rdata[RW];
    assign mvalid_now = (r_seen >= eff_win) && (r_count != '0);
    assign slot_inc   = WW'(r_slot) + WW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rill_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        ring_re     = 1'b0;
        ring_we     = 1'b0;
        div_req     = '0;
        unique case (r_state)
            rill_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = rill_pkg::S_MUL;
                end
            end
            rill_pkg::S_MUL: begin
                ring_re = 1'b1;
                n_state = rill_pkg::S_DEN;
            end
            rill_pkg::S_DEN: begin
                n_state = rill_pkg::S_RSTART;
            end
            rill_pkg::S_RSTART: begin
                // ratio = (prod << 32) / den
                div_req.start = r_has_ratio;
                div_req.hi    = rill_pkg::DEN_W'(r_prod[rill_pkg::PROD_W-1:RW-rill_pkg::FRAC_W]);
                div_req.lo    = {r_prod[RW-rill_pkg::FRAC_W-1:0], rill_pkg::FRAC_W'(0)};
                div_req.den   = r_den;
                n_state       = r_has_ratio ? rill_pkg::S_RWAIT : rill_pkg::S_UPD;
            end
            rill_pkg::S_RWAIT: begin
                if (div_rsp.done) begin
                    n_state = rill_pkg::S_UPD;
                end
            end
            rill_pkg::S_UPD: begin
                ring_we = 1'b1;
                n_state = rill_pkg::S_MSTART;
            end
            rill_pkg::S_MSTART: begin
                div_req.start = mvalid_now;
                div_req.hi    = rill_pkg::DEN_W'(r_sum[SW-1:RW]);
                div_req.lo    = r_sum[RW-1:0];
                div_req.den   = rill_pkg::DEN_W'(r_count);
                n_state       = mvalid_now ? rill_pkg::S_MWAIT : rill_pkg::S_OUT;
            end
            rill_pkg::S_MWAIT: begin
                if (div_rsp.done) begin
                    n_state = rill_pkg::S_OUT;
                end
            end
            rill_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = rill_pkg::S_IDLE;
                end
            end
            default: n_state = rill_pkg::S_IDLE;
        endcase
    end

    // per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first  <= i_bar.first_bar;
            r_close  <= i_bar.close_price;
            r_amount <= i_bar.traded_amount;
        end
        if (r_state == rill_pkg::S_MUL) begin
            r_prod      <= rill_pkg::PROD_W'(diff) * rill_pkg::PROD_W'(cfg.scale_factor);
            r_den       <= rill_pkg::DEN_W'(prev_eff) * rill_pkg::DEN_W'(r_amount[31:0]);
            r_valid     <= r_amount != '0;
            r_has_ratio <= (r_amount != '0) && (prev_eff != '0) && (r_close != prev_eff);
        end
        if (r_state == rill_pkg::S_DEN) begin
            r_den <= r_den + {rill_pkg::AMT_W'(r_prev)
                              * rill_pkg::AMT_W'(r_amount[rill_pkg::AMT_W-1:32]),
                              32'b0};
        end
        if (r_state == rill_pkg::S_RSTART && !r_has_ratio) begin
            r_ratio <= '0;
        end
        if (r_state == rill_pkg::S_RWAIT && div_rsp.done) begin
            r_ratio <= div_rsp.quot;
        end
        if (r_state == rill_pkg::S_MSTART) begin
            r_mvalid <= mvalid_now;
            if (!mvalid_now) begin
                r_mean <= '0;
            end
        end
        if (r_state == rill_pkg::S_MWAIT && div_rsp.done) begin
            r_mean <= div_rsp.quot;
        end
    end

    // window history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_seen  <= '0;
            r_slot  <= '0;
            r_prev  <= '0;
        end else if (cfg.clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_seen  <= '0;
            r_slot  <= '0;
        end else if (r_state == rill_pkg::S_MUL) begin
            if (r_first) begin
                r_sum   <= '0;
                r_count <= '0;
                r_seen  <= '0;
            end
            r_slot <= slot_eff;
            r_prev <= prev_eff;
        end else if (r_state == rill_pkg::S_UPD) begin
            r_sum   <= r_sum - (evict ? SW'(ring_rdata[RW-1:0]) : SW'(0))
                             + (r_valid ? SW'(r_ratio) : SW'(0));
            r_count <= r_count - WW'(evict) + WW'(r_valid);
            r_slot  <= (slot_inc >= eff_win) ? '0 : slot_inc[AW-1:0];
            if (r_seen < eff_win) begin
                r_seen <= r_seen + WW'(1);
            end
            r_prev  <= r_close;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_ratio  <= r_ratio;
            r_o_rvalid <= r_valid;
            r_o_mean   <= r_mean;
            r_o_mvalid <= r_mvalid;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.bar_ratio       = r_o_ratio;
    assign o_res.bar_ratio_valid = r_o_rvalid;
    assign o_res.window_mean     = r_o_mean;
    assign o_res.mean_valid      = r_o_mvalid;

    `RILL_ASSERT_IMP(a_count_le_seen, 1'b1, r_count <= r_seen)
    `RILL_ASSERT_IMP(a_ring_wr_in_window, ring_we, WW'(r_slot) < eff_win)
    `RILL_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy)
    `RILL_ASSERT_NXT(a_one_bar_at_a_time, accept, !i_bar.ready)
endmodule
